### src/linear_probe_hash_table_assert.svh
// Assertion macros for the hash table block.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash table check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash table check failed");

`endif

### src/lpht_pkg.sv
package lpht_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_UPDATE = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  localparam int CFG_W       = 11;
  localparam logic [CFG_W-1:0] MOD_RESET = 11'd1019;
  localparam int FILL_W      = 11;
  localparam int LEN_W       = 4;
  localparam int KEY_IN_W    = 64;
  localparam int VAL_IN_W    = 32;
  localparam int HASH_W      = 32;
  localparam logic [HASH_W-1:0] HASH_MUL = 32'd101;
  localparam int DIV_CNT_W   = 5;
  localparam int S_DATA_W    = 104;
  localparam int M_DATA_W    = 40;

  typedef struct packed {
    logic clr_write;
    logic req_load;
    logic hash_step;
    logic div_init;
    logic div_step;
    logic probe_init;
    logic probe_chk;
    logic commit;
  } lpht_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_done;
    logic div_last;
    logic probe_stop;
    logic out_free;
  } lpht_sts_t;

endpackage

### src/lpht_ram.sv
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/lpht_dp.sv
module lpht_dp import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  lpht_cmd_t           cmd,
  output lpht_sts_t           sts,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [1:0]          op,
  input  logic [KEY_IN_W-1:0] key_text,
  input  logic [LEN_W-1:0]    key_len,
  input  logic [VAL_IN_W-1:0] entry_value,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic                found,
  output logic [VAL_IN_W-1:0] read_value
);

  localparam int KEY_USE = (KEY_BYTES < 8) ? KEY_BYTES : 8;
  localparam int KEY_W   = 8 * KEY_USE;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int M_W     = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W   = (M_W > 12) ? M_W : 12;
  localparam int WORD_W  = 2 + LEN_W + KEY_W + VALUE_BITS;

  logic [CFG_W-1:0]      modulus;
  logic [M_W-1:0]        eff_m;
  logic [CMP_W-1:0]      mod_ext;
  op_t                   op_q;
  logic [LEN_W-1:0]      len_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [LEN_W-1:0]      len_sat;
  logic [KEY_IN_W-1:0]   key_masked;
  logic [LEN_W-1:0]      byte_cnt;
  logic [HASH_W-1:0]     hash_q;
  logic [KEY_IN_W-1:0]   key_full;
  logic [2:0]            bsel;
  logic [7:0]            cbyte;
  logic [HASH_W-1:0]     dvd_q;
  logic [M_W-1:0]        rem_q;
  logic [M_W:0]          shifted;
  logic [M_W:0]          rem_next;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [IDX_W-1:0]      idx_q;
  logic [M_W-1:0]        n_q;
  logic [IDX_W-1:0]      cand_idx;
  logic                  cand_ok;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [VALUE_BITS-1:0] hit_val;
  logic [FILL_W-1:0]     fill;
  logic [IDX_W-1:0]      clr_addr;
  logic [WORD_W-1:0]     rdata;
  logic                  s_used;
  logic                  s_tomb;
  logic [LEN_W-1:0]      s_len;
  logic [KEY_W-1:0]      s_key;
  logic [VALUE_BITS-1:0] s_val;
  logic                  s_empty;
  logic                  s_match;
  logic                  s_last;
  logic                  tbl_full;
  logic                  do_write;
  status_t               st_next;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [WORD_W-1:0]     wdata;

  // Config and effective modulus.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  always_comb begin
    mod_ext = CMP_W'(modulus);
    if (mod_ext < CMP_W'(2)) begin
      eff_m = M_W'(2);
    end else if (mod_ext > CMP_W'(TABLE_DEPTH)) begin
      eff_m = M_W'(TABLE_DEPTH);
    end else begin
      eff_m = M_W'(mod_ext);
    end
  end

  // Request capture.
  always_comb begin
    len_sat = (key_len > LEN_W'(KEY_USE)) ? LEN_W'(KEY_USE) : key_len;
    for (int i = 0; i < 8; i++) begin
      key_masked[8*i +: 8] = (LEN_W'(i) < len_sat) ? key_text[8*i +: 8] : 8'd0;
    end
  end

  // Hash byte selection, highest valid key byte first.
  assign key_full = KEY_IN_W'(key_q);
  assign bsel     = 3'(byte_cnt - LEN_W'(1));
  assign cbyte    = key_full[{bsel, 3'b000} +: 8];

  // Restoring remainder step.
  assign shifted  = {rem_q, dvd_q[HASH_W-1]};
  assign rem_next = (shifted >= {1'b0, eff_m}) ? shifted - {1'b0, eff_m} : shifted;

  // Slot decode.
  assign {s_used, s_tomb, s_len, s_key, s_val} = rdata;
  assign s_empty = !s_used;
  assign s_match = s_used && !s_tomb && (s_len == len_q) && (s_key == key_q);
  assign s_last  = (n_q + M_W'(1)) == eff_m;

  // Final decision.
  assign tbl_full = CMP_W'({fill, 1'b0}) > CMP_W'(eff_m);
  always_comb begin
    if (op_q == OP_INSERT) begin
      priority if (hit) begin
        st_next = ST_DUP;
      end else if (tbl_full || !cand_ok) begin
        st_next = ST_FULL;
      end else begin
        st_next = ST_OK;
      end
      do_write = !hit && !tbl_full && cand_ok;
    end else begin
      st_next  = hit ? ST_OK : ST_MISS;
      do_write = hit && (op_q != OP_LOOKUP);
    end
  end

  assign we    = cmd.clr_write || (cmd.commit && do_write);
  assign waddr = cmd.clr_write ? clr_addr : ((op_q == OP_INSERT) ? cand_idx : hit_idx);
  assign wdata = cmd.clr_write ? '0 :
                 {1'b1, (op_q == OP_REMOVE), len_q, key_q, val_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_write) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (cmd.commit && do_write && (op_q == OP_INSERT) && (fill != '1)) begin
        fill <= fill + FILL_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_q     <= op_t'(op);
      len_q    <= len_sat;
      key_q    <= key_masked[KEY_W-1:0];
      val_q    <= VALUE_BITS'({32'd0, entry_value});
      byte_cnt <= len_sat;
      hash_q   <= '0;
    end
    if (cmd.hash_step) begin
      hash_q   <= hash_q * HASH_MUL + {{24{cbyte[7]}}, cbyte};
      byte_cnt <= byte_cnt - LEN_W'(1);
    end
    if (cmd.div_init) begin
      dvd_q   <= hash_q[HASH_W-1] ? HASH_W'(0) - hash_q : hash_q;
      rem_q   <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem_q   <= rem_next[M_W-1:0];
      dvd_q   <= {dvd_q[HASH_W-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.probe_init) begin
      idx_q   <= rem_q[IDX_W-1:0];
      n_q     <= '0;
      cand_ok <= 1'b0;
      hit     <= 1'b0;
    end
    if (cmd.probe_chk) begin
      if ((s_empty || s_tomb) && !cand_ok) begin
        cand_idx <= idx_q;
        cand_ok  <= 1'b1;
      end
      if (s_match) begin
        hit     <= 1'b1;
        hit_idx <= idx_q;
        hit_val <= s_val;
      end else begin
        idx_q <= ((M_W'(idx_q) + M_W'(1)) == eff_m) ? '0 : idx_q + IDX_W'(1);
        n_q   <= n_q + M_W'(1);
      end
    end
    if (cmd.commit) begin
      status     <= st_next;
      found      <= hit;
      read_value <= (op_q == OP_LOOKUP && hit) ? VAL_IN_W'(64'(hit_val)) : '0;
    end
  end

  lpht_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_q),
    .rdata(rdata)
  );

  assign sts.clr_last   = clr_addr == IDX_W'(TABLE_DEPTH - 1);
  assign sts.hash_done  = byte_cnt == '0;
  assign sts.div_last   = div_cnt == DIV_CNT_W'(HASH_W - 1);
  assign sts.probe_stop = s_empty || s_match || s_last;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

### src/lpht_ctrl.sv
module lpht_ctrl import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lpht_sts_t sts,
  input  logic      in_valid,
  output logic      in_ready,
  output lpht_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_DIV, S_HOME, S_RD, S_CHK, S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: if (sts.clr_last) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_HASH;
        S_HASH:  if (sts.hash_done) state <= S_DIV;
        S_DIV:   if (sts.div_last) state <= S_HOME;
        S_HOME:  state <= S_RD;
        S_RD:    state <= S_CHK;
        S_CHK:   state <= sts.probe_stop ? S_DONE : S_RD;
        S_DONE:  if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.clr_write  = state == S_CLEAR;
    cmd.req_load   = (state == S_IDLE) && in_valid;
    cmd.hash_step  = (state == S_HASH) && !sts.hash_done;
    cmd.div_init   = (state == S_HASH) && sts.hash_done;
    cmd.div_step   = state == S_DIV;
    cmd.probe_init = state == S_HOME;
    cmd.probe_chk  = state == S_CHK;
    cmd.commit     = (state == S_DONE) && sts.out_free;
  end

  assign in_ready = state == S_IDLE;

endmodule

### src/linear_probe_hash_table.sv
// Sequence: load, one hash step per key byte, a bit-serial remainder, then a slot read
//   and check per probe and a commit; one item in flight at a time.
// The remainder unit works one bit per cycle and the RAM has a single read port.
// Reset: synchronous; fill count and modulus (1019) reset, then a clearing pass
//   writes every slot before the first item is taken.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BITS  = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // op[1:0], key_text[65:2], key_len[69:66], entry_value[101:70], zero pad
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // status[1:0], found[2], read_value[34:3], zero pad
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data
);

  lpht_cmd_t           cmd;
  lpht_sts_t           sts;
  logic [1:0]          status;
  logic                found;
  logic [VAL_IN_W-1:0] read_value;

  // Every modulus write is taken; user must send writes only while idle, unchecked.
  assign cfg_ready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .sts     (sts),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .cmd     (cmd)
  );

  // Hash, remainder, probe walk, slot store and the output register.
  lpht_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES  (KEY_BYTES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .op         (s_tdata[1:0]),
    .key_text   (s_tdata[65:2]),
    .key_len    (s_tdata[69:66]),
    .entry_value(s_tdata[101:70]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .status     (status),
    .found      (found),
    .read_value (read_value)
  );

  // Pack the result item, status in the low bits.
  assign m_tdata = {5'd0, read_value, found, status};

`include "linear_probe_hash_table_assert.svh"

  // An accepted item makes the block busy in the next cycle.
  `LPHT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // No item is taken during the clearing pass.
  `LPHT_ASSERT_NOW(a_no_accept_clearing, cmd.clr_write, !s_tready)
  // A result is loaded only when the output register is free.
  `LPHT_ASSERT_NOW(a_commit_free, cmd.commit, !m_tvalid || m_tready)

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb import lpht_pkg::*;;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] entry_value;
    logic [3:0]  key_len;
    logic [63:0] key_text;
    op_t         op;
  } request_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        found;
    status_t     status;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [M_DATA_W-1:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  linear_probe_hash_table i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the table
  bit          tab_used [DEPTH];
  bit          tab_tomb [DEPTH];
  logic [63:0] tab_key  [DEPTH];
  logic [3:0]  tab_len  [DEPTH];
  logic [31:0] tab_val  [DEPTH];
  int unsigned fill_cnt;
  logic [CFG_W-1:0] modulus_reg;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int unsigned cycle_cnt = 0;
  bit stim_done = 0;

  // Random keys drawn so far, reused to hit duplicates and live entries
  logic [63:0] key_pool[$];
  logic [3:0]  len_pool[$];

  function automatic int unsigned active_modulus();
    int unsigned m;
    m = modulus_reg;
    if (m < 2) m = 2;
    if (m > DEPTH) m = DEPTH;
    return m;
  endfunction

  function automatic int unsigned home_index(logic [63:0] k, int unsigned len, int unsigned m);
    logic [31:0] h;
    logic [7:0] c;
    h = 0;
    for (int i = 0; i < len; i++) begin
      c = k[8*(len-1-i) +: 8];
      h = h * 32'd101 + {{24{c[7]}}, c};
    end
    if (h[31]) h = -h;
    return h % m;
  endfunction

  // Apply one request to the shadow table and return the answer
  function automatic answer_t hash_table_step(request_t r);
    answer_t a;
    int unsigned m, len, idx, hit;
    logic [63:0] k;
    bit present;
    m = active_modulus();
    len = r.key_len > 8 ? 8 : r.key_len;
    k = len == 8 ? r.key_text : r.key_text & ((64'd1 << (8*len)) - 1);
    a = '0;
    present = 0;
    idx = home_index(k, len, m);
    for (int n = 0; n < m; n++) begin
      if (!tab_used[idx]) break;
      if (!tab_tomb[idx] && tab_len[idx] == len && tab_key[idx] == k) begin
        present = 1;
        hit = idx;
        break;
      end
      idx = (idx + 1) % m;
    end
    a.found = present;
    a.status = ST_OK;
    if (r.op == OP_INSERT) begin
      if (present) a.status = ST_DUP;
      else if (fill_cnt * 2 > m) a.status = ST_FULL;
      else begin
        a.status = ST_FULL;
        idx = home_index(k, len, m);
        for (int n = 0; n < m; n++) begin
          if (tab_tomb[idx] || !tab_used[idx]) begin
            tab_tomb[idx] = 0;
            tab_used[idx] = 1;
            tab_key[idx] = k;
            tab_len[idx] = 4'(len);
            tab_val[idx] = r.entry_value;
            if (fill_cnt < 2047) fill_cnt++;
            a.status = ST_OK;
            break;
          end
          idx = (idx + 1) % m;
        end
      end
    end else if (!present) a.status = ST_MISS;
    else if (r.op == OP_LOOKUP) a.read_value = tab_val[hit];
    else if (r.op == OP_UPDATE) tab_val[hit] = r.entry_value;
    else tab_tomb[hit] = 1;
    return a;
  endfunction

  // Driver: present pending items, with a random gap after each
  int send_gap = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_answers.push_back(hash_table_step(request_t'(s_tdata[101:0])));
        void'(pending_reqs.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // hold the item
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 0;
      end else if (pending_reqs.size() > 0) begin
        s_tvalid <= 1;
        s_tdata <= {2'b0, pending_reqs[0]};
        send_gap <= $urandom_range(0, 3);
      end else s_tvalid <= 0;
    end
  end

  // Monitor: random stalls, compare each answer with the oldest expectation
  int recv_gap = 0;
  int recv_draw;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_answers.size() == 0) begin
          errors++;
          $display("%0t: unexpected answer %h", $time, m_tdata);
        end else begin
          answer_t e, g;
          e = expected_answers.pop_front();
          g = answer_t'(m_tdata[34:0]);
          if (g.status !== e.status)
            $display("%0t: status exp %0d got %0d", $time, e.status, g.status);
          if (g.found !== e.found)
            $display("%0t: found exp %0d got %0d", $time, e.found, g.found);
          if (g.read_value !== e.read_value)
            $display("%0t: read_value exp %h got %h", $time, e.read_value, g.read_value);
          if (g !== e) errors++;
        end
        recv_draw = $urandom_range(0, 3);
        recv_gap <= recv_draw;
        m_tready <= (recv_draw == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= (recv_gap == 1);
      end else m_tready <= 1;
    end
  end

  task automatic queue_req(op_t op, logic [63:0] k, logic [3:0] len, logic [31:0] v);
    request_t r;
    r.op = op; r.key_text = k; r.key_len = len; r.entry_value = v;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || s_tvalid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_modulus(logic [CFG_W-1:0] m);
    cfg_valid <= 1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    modulus_reg = m;
  endtask

  // Mostly well-formed traffic on a small key pool, some noise keys
  task automatic random_phase(int count);
    logic [63:0] k;
    logic [3:0] len;
    for (int i = 0; i < count; i++) begin
      if (key_pool.size() > 0 && $urandom_range(0, 99) < 65) begin
        int j;
        j = $urandom_range(0, key_pool.size() - 1);
        k = key_pool[j]; len = len_pool[j];
      end else begin
        k = {$urandom, $urandom};
        len = $urandom_range(0, 99) < 10 ? $urandom_range(9, 15) : $urandom_range(0, 8);
        key_pool.push_back(k); len_pool.push_back(len);
      end
      queue_req(op_t'($urandom_range(0, 3)), k, len, $urandom);
    end
    drain();
  endtask

  initial begin
    foreach (tab_used[i]) begin
      tab_used[i] = 0; tab_tomb[i] = 0;
    end
    fill_cnt = 0;
    modulus_reg = MOD_RESET;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed: extremes, every operation, long keys, high key bits ignored
    queue_req(OP_LOOKUP, 64'h0, 4'd0, 32'h0);
    queue_req(OP_INSERT, 64'h0, 4'd0, 32'hFFFF_FFFF);
    queue_req(OP_INSERT, 64'h0, 4'd0, 32'h1);
    queue_req(OP_LOOKUP, 64'hFF00, 4'd0, 32'h0);
    queue_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h1234_5678);
    queue_req(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0);
    queue_req(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'hDEAD_BEEF);
    queue_req(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    queue_req(OP_INSERT, 64'hAAAA_5555_0080_7F81, 4'd3, 32'h5555_AAAA);
    queue_req(OP_LOOKUP, 64'h0000_0000_0080_7F81, 4'd3, 32'h0);
    queue_req(OP_REMOVE, 64'h0080_7F81, 4'd3, 32'h0);
    queue_req(OP_LOOKUP, 64'h0080_7F81, 4'd3, 32'h0);
    queue_req(OP_REMOVE, 64'h0080_7F81, 4'd3, 32'h0);
    queue_req(OP_UPDATE, 64'h0080_7F81, 4'd3, 32'h0);
    queue_req(OP_INSERT, 64'h0080_7F81, 4'd3, 32'h7);
    queue_req(OP_LOOKUP, 64'h0080_7F81, 4'd3, 32'h0);
    drain();

    // Tiny modulus: collisions, wrap, table full
    write_modulus(11'd0);
    for (int i = 0; i < 6; i++) queue_req(OP_INSERT, 64'h41 + i, 4'd1, i);
    for (int i = 0; i < 6; i++) queue_req(OP_LOOKUP, 64'h41 + i, 4'd1, 0);
    drain();
    random_phase(40);

    write_modulus(11'd2047);
    random_phase(100);
    write_modulus(11'd7);
    random_phase(60);
    write_modulus(11'd1024);
    random_phase(100);
    write_modulus(11'd1);
    random_phase(30);
    write_modulus(11'd97);
    random_phase(100);
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (stim_done) begin
      if (errors == 0) $display("** linear_probe_hash_table: PASSED **");
      else $display("** linear_probe_hash_table: FAILED **");
      $finish;
    end else if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** linear_probe_hash_table: FAILED **");
      $finish;
    end
  end
endmodule
